/* design/sts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_pkg
// Types and constants shared by the source token scanner.
// ----------------------------------------------------------------------------
package sts_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } in_req_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [3:0]  keyword_id;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [11:0] token_length;
    logic        last_of_run;
  } out_req_t;

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_WORD, MODE_NUMBER, MODE_OPERATOR, MODE_COMMENT
  } mode_t;

  localparam logic [4:0] KIND_EOF      = 5'd0;
  localparam logic [4:0] KIND_ILLEGAL  = 5'd1;
  localparam logic [4:0] KIND_IDENT    = 5'd2;
  localparam logic [4:0] KIND_KEYWORD  = 5'd3;
  localparam logic [4:0] KIND_DATATYPE = 5'd4;
  localparam logic [4:0] KIND_INT      = 5'd5;
  localparam logic [4:0] KIND_FLOAT    = 5'd6;
  localparam logic [4:0] KIND_ASSIGN   = 5'd7;
  localparam logic [4:0] KIND_PLUS     = 5'd9;
  localparam logic [4:0] KIND_MINUS    = 5'd11;
  localparam logic [4:0] KIND_STAR     = 5'd13;
  localparam logic [4:0] KIND_SLASH    = 5'd14;
  localparam logic [4:0] KIND_BANG     = 5'd15;
  localparam logic [4:0] KIND_LESS     = 5'd17;
  localparam logic [4:0] KIND_GREATER  = 5'd19;
  localparam logic [4:0] KIND_LPAREN   = 5'd21;
  localparam logic [4:0] KIND_RPAREN   = 5'd22;
  localparam logic [4:0] KIND_LBRACE   = 5'd23;
  localparam logic [4:0] KIND_RBRACE   = 5'd24;
  localparam logic [4:0] KIND_COMMA    = 5'd25;
  localparam logic [4:0] KIND_SEMI     = 5'd26;
  localparam logic [4:0] KIND_COLON    = 5'd27;

  localparam logic [15:0] POS_MAX   = 16'hFFFF;
  localparam logic [11:0] COUNT_MAX = 12'hFFF;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [4:0] single_kind(input logic [7:0] op);
    logic [4:0] k;
    unique case (op)
      "=": k = KIND_ASSIGN;
      "+": k = KIND_PLUS;
      "-": k = KIND_MINUS;
      "/": k = KIND_SLASH;
      "!": k = KIND_BANG;
      "<": k = KIND_LESS;
      default: k = KIND_GREATER;
    endcase
    return k;
  endfunction

endpackage

/* design/sts_keyword_match.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_keyword_match
// Compares the buffered word against the keyword list.
// ----------------------------------------------------------------------------
module sts_keyword_match #(
  parameter int KEYWORD_CHARS = 6
) (
  input  logic [KEYWORD_CHARS*8-1:0] word,
  input  logic [11:0]                count,
  input  logic                       possible,
  output logic [4:0]                 kind,
  output logic [3:0]                 id
);

  function automatic logic hit(input logic [KEYWORD_CHARS*8-1:0] w,
                               input logic [11:0] n,
                               input logic [47:0] txt,
                               input logic [3:0] len);
    logic ok;
    ok = (n == 12'(len)) && (int'(len) <= KEYWORD_CHARS);
    for (int i = 0; i < 6; i++) begin
      if (i < int'(len) && i < KEYWORD_CHARS && w[i*8 +: 8] != txt[i*8 +: 8])
        ok = 1'b0;
    end
    return ok;
  endfunction

  // text stored first character in the low byte
  logic [47:0] kt [9];
  logic [3:0]  kl [9];
  assign kt[0] = 48'h0000_0074_656C; assign kl[0] = 4'd3;
  assign kt[1] = 48'h0000_0000_6E66; assign kl[1] = 4'd2;
  assign kt[2] = 48'h6E72_7574_6572; assign kl[2] = 4'd6;
  assign kt[3] = 48'h0000_0000_6669; assign kl[3] = 4'd2;
  assign kt[4] = 48'h0000_6573_6C65; assign kl[4] = 4'd4;
  assign kt[5] = 48'h0000_6575_7274; assign kl[5] = 4'd4;
  assign kt[6] = 48'h0065_736C_6166; assign kl[6] = 4'd5;
  assign kt[7] = 48'h0000_0074_6E69; assign kl[7] = 4'd3;
  assign kt[8] = 48'h0074_616F_6C66; assign kl[8] = 4'd5;

  // pick first matching keyword
  always_comb begin
    kind = sts_pkg::KIND_IDENT;
    id   = 4'd0;
    if (possible) begin
      for (int k = 8; k >= 0; k--) begin
        if (hit(word, count, kt[k], kl[k])) begin
          kind = (k >= 7) ? sts_pkg::KIND_DATATYPE : sts_pkg::KIND_KEYWORD;
          id   = 4'(k);
        end
      end
    end
  end

endmodule

/* design/sts_out_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_out_queue
// Two-entry result queue; accepts up to two results per cycle.
// ----------------------------------------------------------------------------
module sts_out_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_n,
  input  sts_pkg::out_req_t push0,
  input  sts_pkg::out_req_t push1,
  output logic              space2,
  output logic              out_valid,
  input  logic              out_ready,
  output sts_pkg::out_req_t out_data
);

  sts_pkg::out_req_t slot0, slot1;
  logic [1:0] fill;
  logic pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = fill != 2'd0;
  assign out_data  = slot0;
  // room for two after this cycle's pop
  assign space2    = (fill == 2'd0) || (fill == 2'd1 && pop);

  // shift out head, append new results
  always_ff @(posedge clk) begin
    sts_pkg::out_req_t a, b;
    logic [1:0] f;
    a = slot0; b = slot1; f = fill;
    if (pop) begin
      a = b; f = f - 2'd1;
    end
    if (push_n != 2'd0) begin
      if (f == 2'd0) begin
        a = push0; b = push1;
      end else begin
        b = push0;
      end
      f = f + push_n;
    end
    slot0 <= a; slot1 <= b;
    if (rst) fill <= 2'd0;
    else     fill <= f;
  end

endmodule

/* design/source_token_scanner.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_token_scanner
// Classifies a byte stream into tokens with position and length.
// ----------------------------------------------------------------------------
// Usage:
//   in  channel: one source byte per request (char_code, end_of_input).
//   out channel: classified tokens; one byte yields zero, one or two
//   tokens, the last of them flagged by last_of_run.
//   Each byte is scanned in the cycle it is accepted and its tokens land
//   in a two-entry output queue, visible in the cycle after.
//   Throughput: one byte per cycle while the queue drains; the input
//   stalls when the queue cannot take two more tokens, so a stalled
//   receiver holds the scanner without losing tokens. A byte that yields
//   two tokens fills the queue, so the next byte stalls.
//   End of input flushes the pending token, emits eof and returns the
//   scanner to line 1, column 1.
//   Reset (rst, synchronous) clears scanner state and empties the queue.
// ----------------------------------------------------------------------------
module source_token_scanner #(
  parameter int KEYWORD_CHARS = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sts_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sts_pkg::out_req_t out_data
);
  localparam int IW = (KEYWORD_CHARS > 1) ? $clog2(KEYWORD_CHARS) : 1;

  sts_pkg::mode_t mode, mode_next;
  logic [7:0]  pend, pend_next;
  logic [KEYWORD_CHARS*8-1:0] word, word_next;
  logic kw_ok, kw_ok_next, point, point_next;
  logic [15:0] tline, tline_next, tcol, tcol_next, cline, cline_next, ccol, ccol_next;
  logic [11:0] cnt, cnt_next;
  logic [1:0]  n;
  sts_pkg::out_req_t r0, r1;
  logic [4:0] wkind;
  logic [3:0] wid;
  logic space2, acc;

  sts_keyword_match #(.KEYWORD_CHARS(KEYWORD_CHARS)) u_kw (
    .word(word), .count(cnt), .possible(kw_ok), .kind(wkind), .id(wid)
  );

  assign in_ready = space2;
  assign acc = in_valid && in_ready;

  // scan one byte
  always_comb begin
    logic [7:0] c;
    logic at_end, restart, fl;
    sts_pkg::out_req_t t, p;
    c = in_data.char_code;
    at_end = in_data.end_of_input || c == 8'd0;
    mode_next = mode; pend_next = pend; word_next = word; kw_ok_next = kw_ok;
    point_next = point; tline_next = tline; tcol_next = tcol; cnt_next = cnt;
    cline_next = cline; ccol_next = ccol;
    n = 2'd0; r0 = '0; r1 = '0; restart = 1'b0; fl = 1'b0;
    t = '0;
    // flushed pending token
    p = '0;
    p.start_line = tline; p.start_column = tcol; p.token_length = cnt;
    unique case (mode)
      sts_pkg::MODE_WORD: begin p.token_kind = wkind; p.keyword_id = wid; end
      sts_pkg::MODE_NUMBER:
        p.token_kind = point ? sts_pkg::KIND_FLOAT : sts_pkg::KIND_INT;
      sts_pkg::MODE_OPERATOR: begin
        p.token_kind = sts_pkg::single_kind(pend); p.token_length = 12'd1;
      end
      default: p.token_kind = sts_pkg::KIND_EOF;
    endcase
    if (at_end) begin
      t = '0;
      t.token_kind = sts_pkg::KIND_EOF;
      t.start_line = cline; t.start_column = ccol; t.last_of_run = 1'b1;
      if (mode == sts_pkg::MODE_WORD || mode == sts_pkg::MODE_NUMBER ||
          mode == sts_pkg::MODE_OPERATOR) begin
        r0 = p; r1 = t; n = 2'd2;
      end else begin
        r0 = t; n = 2'd1;
      end
      mode_next = sts_pkg::MODE_IDLE; pend_next = '0; word_next = '0;
      kw_ok_next = 1'b1; point_next = 1'b0; tline_next = 16'd1; tcol_next = 16'd1;
      cnt_next = '0; cline_next = 16'd1; ccol_next = 16'd1;
    end else begin
      if (c == 8'h0A) begin
        if (cline != sts_pkg::POS_MAX) cline_next = cline + 16'd1;
        ccol_next = 16'd1;
      end else if (ccol != sts_pkg::POS_MAX) begin
        ccol_next = ccol + 16'd1;
      end
      unique case (mode)
        sts_pkg::MODE_WORD: begin
          if (sts_pkg::is_letter(c)) begin
            if (cnt < 12'(KEYWORD_CHARS)) word_next[cnt[IW-1:0]*8 +: 8] = c;
            else kw_ok_next = 1'b0;
            if (cnt != sts_pkg::COUNT_MAX) cnt_next = cnt + 12'd1;
          end else begin
            fl = 1'b1; restart = 1'b1;
          end
        end
        sts_pkg::MODE_NUMBER: begin
          if (sts_pkg::is_digit(c) || c == "_" || (c == "." && !point)) begin
            if (c == ".") point_next = 1'b1;
            if (cnt != sts_pkg::COUNT_MAX) cnt_next = cnt + 12'd1;
          end else begin
            fl = 1'b1; restart = 1'b1;
          end
        end
        sts_pkg::MODE_OPERATOR: begin
          if (pend == "/" && c == "/") begin
            mode_next = sts_pkg::MODE_COMMENT;
          end else if ((c == "=" && (pend == "=" || pend == "!" || pend == "<" ||
                        pend == ">")) || ((pend == "+" || pend == "-") && c == pend)) begin
            r0.token_kind = sts_pkg::single_kind(pend) + 5'd1;
            r0.start_line = tline; r0.start_column = tcol;
            r0.token_length = 12'd2; r0.last_of_run = 1'b1;
            n = 2'd1; mode_next = sts_pkg::MODE_IDLE;
          end else begin
            fl = 1'b1; restart = 1'b1;
          end
        end
        sts_pkg::MODE_COMMENT: begin
          if (c == 8'h0A) mode_next = sts_pkg::MODE_IDLE;
        end
        default: restart = 1'b1;
      endcase
      if (restart) begin
        t = '0;
        t.start_line = cline; t.start_column = ccol; t.token_length = 12'd1;
        t.last_of_run = 1'b1;
        mode_next = sts_pkg::MODE_IDLE;
        tline_next = cline; tcol_next = ccol; cnt_next = 12'd1;
        if (c == " " || c == 8'h0A || c == 8'h09 || c == 8'h0D) begin
          t.token_kind = sts_pkg::KIND_EOF;
        end else if (sts_pkg::is_letter(c)) begin
          mode_next = sts_pkg::MODE_WORD; kw_ok_next = 1'b1;
          word_next[7:0] = c;
        end else if (sts_pkg::is_digit(c)) begin
          mode_next = sts_pkg::MODE_NUMBER; point_next = 1'b0;
        end else if (c == "=" || c == "+" || c == "-" || c == "/" || c == "!" ||
                     c == "<" || c == ">") begin
          mode_next = sts_pkg::MODE_OPERATOR; pend_next = c;
        end else begin
          unique case (c)
            "*": t.token_kind = sts_pkg::KIND_STAR;
            "(": t.token_kind = sts_pkg::KIND_LPAREN;
            ")": t.token_kind = sts_pkg::KIND_RPAREN;
            "{": t.token_kind = sts_pkg::KIND_LBRACE;
            "}": t.token_kind = sts_pkg::KIND_RBRACE;
            ",": t.token_kind = sts_pkg::KIND_COMMA;
            ";": t.token_kind = sts_pkg::KIND_SEMI;
            ":": t.token_kind = sts_pkg::KIND_COLON;
            default: t.token_kind = sts_pkg::KIND_ILLEGAL;
          endcase
        end
        // a new token emitted only for single-char punctuation or illegal
        if (mode_next == sts_pkg::MODE_IDLE && t.token_kind != sts_pkg::KIND_EOF) begin
          if (fl) begin r0 = p; r1 = t; n = 2'd2; end
          else begin r0 = t; n = 2'd1; end
        end else if (fl) begin
          r0 = p; r0.last_of_run = 1'b1; n = 2'd1;
        end
      end
    end
  end

  // hold scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= sts_pkg::MODE_IDLE; pend <= '0; word <= '0; kw_ok <= 1'b1;
      point <= 1'b0; tline <= 16'd1; tcol <= 16'd1; cnt <= '0;
      cline <= 16'd1; ccol <= 16'd1;
    end else if (acc) begin
      mode <= mode_next; pend <= pend_next; word <= word_next; kw_ok <= kw_ok_next;
      point <= point_next; tline <= tline_next; tcol <= tcol_next; cnt <= cnt_next;
      cline <= cline_next; ccol <= ccol_next;
    end
  end

  sts_out_queue u_q (
    .clk(clk), .rst(rst), .push_n(acc ? n : 2'd0), .push0(r0), .push1(r1),
    .space2(space2), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule

/* design/source_token_scanner_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_token_scanner_checker
// Port-level checks for the source token scanner.
// ----------------------------------------------------------------------------
module source_token_scanner_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input sts_pkg::out_req_t out_data
);

  // stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  // nothing out right after reset
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // eof always ends a run
  a_eof: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.token_kind == sts_pkg::KIND_EOF |-> out_data.last_of_run)
    else $error("eof without last flag");

  // positions are 1-based
  a_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.start_line != 16'd0 && out_data.start_column != 16'd0)
    else $error("zero position");

  // empty queue always takes a request
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked while queue empty");

endmodule

bind source_token_scanner source_token_scanner_checker u_chk (.*);

/* tb/source_token_scanner_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_token_scanner_chk
// Watches both channels of the token scanner, predicts the tokens each
// accepted byte should produce and compares them in order with the output.
// ----------------------------------------------------------------------------
module source_token_scanner_chk (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  sts_pkg::in_req_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  sts_pkg::out_req_t out_data,
  output int                fail_count,
  output int                tokens_pending
);

  localparam int WORD_CHARS = 6;

  // scanner state copy
  sts_pkg::mode_t mode_q;
  logic [7:0]  op_q;
  logic [7:0]  word_q [WORD_CHARS];
  logic        kw_ok_q;
  logic        point_q;
  logic [15:0] tok_line_q;
  logic [15:0] tok_col_q;
  logic [11:0] tok_len_q;
  logic [15:0] cur_line_q;
  logic [15:0] cur_col_q;

  sts_pkg::out_req_t token_queue [$];

  assign tokens_pending = token_queue.size();

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
  endfunction

  function automatic logic is_num(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [4:0] lone_kind(logic [7:0] op);
    case (op)
      "=": return sts_pkg::KIND_ASSIGN;
      "+": return sts_pkg::KIND_PLUS;
      "-": return sts_pkg::KIND_MINUS;
      "/": return sts_pkg::KIND_SLASH;
      "!": return sts_pkg::KIND_BANG;
      "<": return sts_pkg::KIND_LESS;
      default: return sts_pkg::KIND_GREATER;
    endcase
  endfunction

  task automatic clear_scan();
    mode_q = sts_pkg::MODE_IDLE;
    op_q = '0;
    for (int i = 0; i < WORD_CHARS; i++) word_q[i] = '0;
    kw_ok_q = 1'b1;
    point_q = 1'b0;
    tok_line_q = 16'd1;
    tok_col_q = 16'd1;
    tok_len_q = '0;
    cur_line_q = 16'd1;
    cur_col_q = 16'd1;
  endtask

  task automatic push_token(ref sts_pkg::out_req_t toks[$], input logic [4:0] kind,
                            input logic [3:0] id, input logic [15:0] ln,
                            input logic [15:0] col, input logic [11:0] len);
    sts_pkg::out_req_t t;
    t.token_kind = kind;
    t.keyword_id = id;
    t.start_line = ln;
    t.start_column = col;
    t.token_length = len;
    t.last_of_run = 1'b0;
    toks.push_back(t);
  endtask

  // classify the buffered word against the keyword list
  task automatic close_word(ref sts_pkg::out_req_t toks[$]);
    string kw [9];
    logic [4:0] kind;
    logic [3:0] id;
    logic same;
    kw = '{"let", "fn", "return", "if", "else", "true", "false", "int", "float"};
    kind = sts_pkg::KIND_IDENT;
    id = '0;
    if (kw_ok_q) begin
      for (int k = 0; k < 9; k++) begin
        same = (tok_len_q == kw[k].len()) && (kw[k].len() <= WORD_CHARS);
        for (int i = 0; same && i < kw[k].len(); i++)
          if (kw[k][i] != word_q[i]) same = 1'b0;
        if (same) begin
          kind = (k >= 7) ? sts_pkg::KIND_DATATYPE : sts_pkg::KIND_KEYWORD;
          id = k[3:0];
          break;
        end
      end
    end
    push_token(toks, kind, id, tok_line_q, tok_col_q, tok_len_q);
  endtask

  task automatic close_pending(ref sts_pkg::out_req_t toks[$]);
    case (mode_q)
      sts_pkg::MODE_WORD: close_word(toks);
      sts_pkg::MODE_NUMBER:
        push_token(toks, point_q ? sts_pkg::KIND_FLOAT : sts_pkg::KIND_INT, '0,
                   tok_line_q, tok_col_q, tok_len_q);
      sts_pkg::MODE_OPERATOR: push_token(toks, lone_kind(op_q), '0, tok_line_q,
                                         tok_col_q, 12'd1);
      default: ;
    endcase
    mode_q = sts_pkg::MODE_IDLE;
  endtask

  task automatic begin_token(ref sts_pkg::out_req_t toks[$], input logic [7:0] c,
                             input logic [15:0] ln, input logic [15:0] col);
    logic [4:0] kind;
    tok_line_q = ln;
    tok_col_q = col;
    tok_len_q = 12'd1;
    if (c == " " || c == 8'h0a || c == 8'h09 || c == 8'h0d) return;
    if (is_alpha(c)) begin
      mode_q = sts_pkg::MODE_WORD;
      kw_ok_q = 1'b1;
      word_q[0] = c;
      return;
    end
    if (is_num(c)) begin
      mode_q = sts_pkg::MODE_NUMBER;
      point_q = 1'b0;
      return;
    end
    case (c)
      "=", "+", "-", "/", "!", "<", ">": begin
        mode_q = sts_pkg::MODE_OPERATOR;
        op_q = c;
        return;
      end
      "*": kind = sts_pkg::KIND_STAR;
      "(": kind = sts_pkg::KIND_LPAREN;
      ")": kind = sts_pkg::KIND_RPAREN;
      "{": kind = sts_pkg::KIND_LBRACE;
      "}": kind = sts_pkg::KIND_RBRACE;
      ",": kind = sts_pkg::KIND_COMMA;
      ";": kind = sts_pkg::KIND_SEMI;
      ":": kind = sts_pkg::KIND_COLON;
      default: kind = sts_pkg::KIND_ILLEGAL;
    endcase
    push_token(toks, kind, '0, ln, col, 12'd1);
  endtask

  // predict the tokens caused by one byte
  task automatic scan_byte(input sts_pkg::in_req_t req);
    sts_pkg::out_req_t toks [$];
    logic [7:0] c;
    logic [15:0] ln, col;
    logic [4:0] kind;
    logic done;
    c = req.char_code;
    ln = cur_line_q;
    col = cur_col_q;
    done = 1'b0;
    if (req.end_of_input || c == 8'h00) begin
      if (mode_q != sts_pkg::MODE_COMMENT) close_pending(toks);
      push_token(toks, sts_pkg::KIND_EOF, '0, cur_line_q, cur_col_q, 12'd0);
      clear_scan();
      done = 1'b1;
    end else begin
      if (c == 8'h0a) begin
        if (cur_line_q != sts_pkg::POS_MAX) cur_line_q++;
        cur_col_q = 16'd1;
      end else if (cur_col_q != sts_pkg::POS_MAX) begin
        cur_col_q++;
      end
      case (mode_q)
        sts_pkg::MODE_WORD: begin
          if (is_alpha(c)) begin
            if (tok_len_q < WORD_CHARS) word_q[tok_len_q[2:0]] = c;
            else kw_ok_q = 1'b0;
            if (tok_len_q != sts_pkg::COUNT_MAX) tok_len_q++;
            done = 1'b1;
          end else close_pending(toks);
        end
        sts_pkg::MODE_NUMBER: begin
          if (is_num(c) || c == "_" || (c == "." && !point_q)) begin
            if (c == ".") point_q = 1'b1;
            if (tok_len_q != sts_pkg::COUNT_MAX) tok_len_q++;
            done = 1'b1;
          end else close_pending(toks);
        end
        sts_pkg::MODE_OPERATOR: begin
          kind = '0;
          if (op_q == "/" && c == "/") begin
            mode_q = sts_pkg::MODE_COMMENT;
            done = 1'b1;
          end else begin
            if (c == "=" && (op_q == "=" || op_q == "!" || op_q == "<" || op_q == ">"))
              kind = lone_kind(op_q) + 5'd1;
            else if ((op_q == "+" || op_q == "-") && c == op_q)
              kind = lone_kind(op_q) + 5'd1;
            if (kind != '0) begin
              push_token(toks, kind, '0, tok_line_q, tok_col_q, 12'd2);
              mode_q = sts_pkg::MODE_IDLE;
              done = 1'b1;
            end else close_pending(toks);
          end
        end
        sts_pkg::MODE_COMMENT: begin
          if (c == 8'h0a) mode_q = sts_pkg::MODE_IDLE;
          done = 1'b1;
        end
        default: mode_q = sts_pkg::MODE_IDLE;
      endcase
      if (!done) begin_token(toks, c, ln, col);
    end
    if (toks.size() > 0) toks[toks.size() - 1].last_of_run = 1'b1;
    foreach (toks[i]) token_queue.push_back(toks[i]);
  endtask

  // track inputs and compare outputs
  always @(posedge clk) begin
    sts_pkg::out_req_t want;
    if (rst) begin
      clear_scan();
      token_queue.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (token_queue.size() == 0) begin
          $display("%0t: unexpected token, expected none, actual %p", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = token_queue.pop_front();
          if (want !== out_data) begin
            $display("%0t: token mismatch, expected %p, actual %p", $time, want,
                     out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) scan_byte(in_data);
    end
  end
endmodule

/* tb/source_token_scanner_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_token_scanner_tb
// Drives source text into the token scanner: directed corner cases, then
// random programs built from real tokens plus byte noise, with random gaps
// and receiver stalls. The checker decides correctness.
// ----------------------------------------------------------------------------
module source_token_scanner_tb;

  localparam int STALL_LIMIT = 20000;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  sts_pkg::in_req_t  in_data;
  logic              out_valid;
  logic              out_ready;
  sts_pkg::out_req_t out_data;
  int                fail_count;
  int                tokens_pending;
  logic              hold_off;
  int                idle_cycles;
  int                rx_gap;

  source_token_scanner i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  source_token_scanner_chk i_chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .tokens_pending(tokens_pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // send one request and wait for its acceptance; valid stays up when
  // the next request follows without a gap
  task automatic send_req(input logic [7:0] c, input logic eoi);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{char_code: c, end_of_input: eoi};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_req(s[i], 1'b0);
  endtask

  // emit one random lexeme drawn from the language, or one random noise byte
  task automatic send_lexeme();
    string kws [9];
    string ops [20];
    string letters;
    string digits;
    string s;
    int n;
    int k;
    kws = '{"let", "fn", "return", "if", "else", "true", "false", "int", "float"};
    ops = '{"==", "!=", "<=", ">=", "++", "--", "=", "+", "-", "*", "/", "!",
            "<", ">", "(", ")", "{", "}", ",", ";"};
    letters = "abcXYZ_qr";
    digits = "0123456789_..";
    s = "";
    case ($urandom_range(0, 9))
      0, 1: s = kws[$urandom_range(0, 8)];
      2: begin
        n = $urandom_range(1, 9);
        for (int i = 0; i < n; i++) begin
          k = $urandom_range(0, 8);
          s = {s, letters.substr(k, k)};
        end
      end
      3: begin
        n = $urandom_range(1, 7);
        for (int i = 0; i < n; i++) begin
          k = $urandom_range(0, 12);
          s = {s, digits.substr(k, k)};
        end
      end
      4, 5: s = ops[$urandom_range(0, 19)];
      6: s = " ";
      7: s = (($urandom_range(0, 1)) ? "\n" : "\t");
      8: s = "// note x\n";
      default: begin
        send_req(8'($urandom_range(1, 255)), 1'b0);
        return;
      end
    endcase
    send_text(s);
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    while (tokens_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // receiver readiness with random stalls and one forced long hold-off
  always @(posedge clk) begin
    if (rst || hold_off) begin
      out_ready <= 1'b0;
      rx_gap <= 0;
    end else if (rx_gap > 0) begin
      out_ready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      rx_gap <= gap_len();
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    hold_off = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // empty text, then directed corner cases
    send_req(8'h41, 1'b1);
    send_text("let fn1 x==y!=z<=a>=b++c--d=e");
    send_req(8'h00, 1'b0);
    send_text("1_2.3.4 abcdefgh // c");
    send_req(8'hFF, 1'b1);
    send_text("<\n>;:,*{}()");
    send_req(8'h80, 1'b0);
    send_text("@!");
    send_req(8'h0D, 1'b0);
    send_text("/");
    send_req(8'h00, 1'b1);
    send_text("float int true false else if return <");
    send_req(8'h20, 1'b1);
    drain_all();
    // long receiver hold-off while bytes keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (40) send_lexeme();
    join
    drain_all();
    // random programs
    for (int i = 0; i < 440; i++) begin
      send_lexeme();
      if ($urandom_range(0, 39) == 0) send_req(8'($urandom_range(0, 255)), 1'b1);
    end
    send_req(8'h00, 1'b1);
    drain_all();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

/* files.f */
design/sts_pkg.sv
design/sts_keyword_match.sv
design/sts_out_queue.sv
design/source_token_scanner.sv
design/source_token_scanner_checker.sv
tb/source_token_scanner_chk.sv
tb/source_token_scanner_tb.sv
